// File: hdl/wacd_pkg.sv
package wacd_pkg;

  localparam int SAMPLE_W         = 12;
  localparam int FIELDS           = 8;
  localparam int WINDOW_DEPTH_DEF = 15;
  localparam int CHANNELS_DEF     = 8;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

// File: hdl/windowed_average_change_detector.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_sample_0 .. in_sample_7
// out      output     out_valid / out_stall  out_average_0 .. out_average_7, out_changed
// cfg      input      cfg_wr_en              cfg_wr_data (change threshold)
//
// The first item after reset only loads the reference. Every later item is
// accepted, then the window memory is read, the sum is updated and written
// back, a bit-serial divide by the held count runs (one quotient bit per
// cycle), and the result is compared and emitted. in_stall stays high until
// the item returns to idle. Reset is synchronous and active low.
// A result waiting on out_stall holds the next item in ST_FINISH.
module windowed_average_change_detector #(
  parameter int WINDOW_DEPTH = wacd_pkg::WINDOW_DEPTH_DEF,
  parameter int CHANNELS     = wacd_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wacd_pkg::SAMPLE_W-1:0] in_sample_0,
  input  logic [wacd_pkg::SAMPLE_W-1:0] in_sample_1,
  input  logic [wacd_pkg::SAMPLE_W-1:0] in_sample_2,
  input  logic [wacd_pkg::SAMPLE_W-1:0] in_sample_3,
  input  logic [wacd_pkg::SAMPLE_W-1:0] in_sample_4,
  input  logic [wacd_pkg::SAMPLE_W-1:0] in_sample_5,
  input  logic [wacd_pkg::SAMPLE_W-1:0] in_sample_6,
  input  logic [wacd_pkg::SAMPLE_W-1:0] in_sample_7,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wacd_pkg::SAMPLE_W-1:0] out_average_0,
  output logic [wacd_pkg::SAMPLE_W-1:0] out_average_1,
  output logic [wacd_pkg::SAMPLE_W-1:0] out_average_2,
  output logic [wacd_pkg::SAMPLE_W-1:0] out_average_3,
  output logic [wacd_pkg::SAMPLE_W-1:0] out_average_4,
  output logic [wacd_pkg::SAMPLE_W-1:0] out_average_5,
  output logic [wacd_pkg::SAMPLE_W-1:0] out_average_6,
  output logic [wacd_pkg::SAMPLE_W-1:0] out_average_7,
  output logic                          out_changed,

  input  logic                          cfg_wr_en,
  input  logic [wacd_pkg::SAMPLE_W-1:0] cfg_wr_data
);

  import wacd_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int ROW_W  = CHANNELS * SAMPLE_W;
  localparam int BIT_W  = $clog2(SAMPLE_W);

  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
  localparam logic [CNT_W:0]    DEPTH_EXT = (CNT_W + 1)'(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [BIT_W-1:0]  LAST_BIT  = BIT_W'(SAMPLE_W - 1);

  logic [SAMPLE_W-1:0] in_smp     [FIELDS];
  logic [SAMPLE_W-1:0] out_avg_r  [FIELDS];

  logic [ROW_W-1:0]    win_mem    [WINDOW_DEPTH];
  logic [ROW_W-1:0]    rd_row_r;
  logic [ROW_W-1:0]    wr_row;

  state_t              state_r, state_nxt;
  logic                ref_loaded_r;
  logic [SAMPLE_W-1:0] thr_r;
  logic [SAMPLE_W-1:0] ref_r      [CHANNELS];
  logic [SAMPLE_W-1:0] cur_r      [CHANNELS];
  logic [SUM_W-1:0]    sum_r      [CHANNELS];
  logic [SUM_W-1:0]    sum_nxt    [CHANNELS];
  logic [CNT_W-1:0]    rem_r      [CHANNELS];
  logic [CNT_W-1:0]    rem_nxt    [CHANNELS];
  logic [SAMPLE_W-1:0] dq_r       [CHANNELS];
  logic [SAMPLE_W-1:0] dq_nxt     [CHANNELS];
  logic [CHANNELS-1:0] over;
  logic [CNT_W-1:0]    held_r;
  logic [SLOT_W-1:0]   oldest_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   slot_nxt;
  logic [BIT_W-1:0]    bit_cnt_r;
  logic                out_valid_r;
  logic                out_changed_r;

  logic                accept;
  logic                rd_en;
  logic                upd_en;
  logic                div_en;
  logic                fin_en;
  logic                emit;
  logic                full;
  logic                changed;

  assign in_smp[0] = in_sample_0;
  assign in_smp[1] = in_sample_1;
  assign in_smp[2] = in_sample_2;
  assign in_smp[3] = in_sample_3;
  assign in_smp[4] = in_sample_4;
  assign in_smp[5] = in_sample_5;
  assign in_smp[6] = in_sample_6;
  assign in_smp[7] = in_sample_7;

  assign accept = in_valid && !in_stall;
  assign full   = (held_r == DEPTH_CNT);
  assign emit   = fin_en && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept && ref_loaded_r) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (bit_cnt_r == LAST_BIT) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control decode
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    upd_en   = 1'b0;
    div_en   = 1'b0;
    fin_en   = 1'b0;
    case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_READ:   rd_en    = 1'b1;
      ST_UPDATE: upd_en   = 1'b1;
      ST_DIVIDE: div_en   = 1'b1;
      ST_FINISH: fin_en   = 1'b1;
      default:   in_stall = 1'b1;
    endcase
  end

  // write slot: append while filling, else overwrite the oldest
  always_comb begin
    logic [CNT_W:0] pos;
    pos = (CNT_W + 1)'(oldest_r) + (CNT_W + 1)'(held_r);
    if (full) begin
      slot_nxt = oldest_r;
    end else if (pos >= DEPTH_EXT) begin
      slot_nxt = SLOT_W'(pos - DEPTH_EXT);
    end else begin
      slot_nxt = SLOT_W'(pos);
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      logic [SUM_W-1:0] old_val;
      logic [CNT_W:0]   trial;
      logic             ge;
      old_val = full ? SUM_W'(rd_row_r[c*SAMPLE_W +: SAMPLE_W]) : '0;
      sum_nxt[c] = sum_r[c] - old_val + SUM_W'(cur_r[c]);
      wr_row[c*SAMPLE_W +: SAMPLE_W] = cur_r[c];
      trial = {rem_r[c], dq_r[c][SAMPLE_W-1]};
      ge = (trial >= {1'b0, held_r});
      rem_nxt[c] = ge ? CNT_W'(trial - {1'b0, held_r}) : CNT_W'(trial);
      dq_nxt[c] = {dq_r[c][SAMPLE_W-2:0], ge};
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      logic [SAMPLE_W-1:0] diff;
      diff = (dq_r[c] >= ref_r[c]) ? dq_r[c] - ref_r[c] : ref_r[c] - dq_r[c];
      over[c] = (diff > thr_r);
    end
  end
  assign changed = |over;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= win_mem[slot_r];
    end
    if (upd_en) begin
      win_mem[slot_r] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ref_loaded_r <= 1'b0;
      thr_r        <= THRESHOLD_RESET;
      held_r       <= '0;
      oldest_r     <= '0;
      bit_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        ref_r[c] <= '0;
        sum_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (accept && !ref_loaded_r) begin
        ref_loaded_r <= 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
          ref_r[c] <= in_smp[c];
        end
      end
      if (upd_en) begin
        for (int c = 0; c < CHANNELS; c++) begin
          sum_r[c] <= sum_nxt[c];
        end
        if (full) begin
          oldest_r <= (oldest_r == LAST_SLOT) ? '0 : oldest_r + 1'b1;
        end else begin
          held_r <= held_r + 1'b1;
        end
      end
      if (upd_en) begin
        bit_cnt_r <= '0;
      end else if (div_en) begin
        bit_cnt_r <= bit_cnt_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        if (changed) begin
          for (int c = 0; c < CHANNELS; c++) begin
            ref_r[c] <= cur_r[c];
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r <= slot_nxt;
      for (int c = 0; c < CHANNELS; c++) begin
        cur_r[c] <= in_smp[c];
      end
    end
    for (int c = 0; c < CHANNELS; c++) begin
      if (upd_en) begin
        rem_r[c] <= sum_nxt[c][SUM_W-1:SAMPLE_W];
        dq_r[c]  <= sum_nxt[c][SAMPLE_W-1:0];
      end else if (div_en) begin
        rem_r[c] <= rem_nxt[c];
        dq_r[c]  <= dq_nxt[c];
      end
    end
    if (emit) begin
      out_changed_r <= changed;
      for (int f = 0; f < FIELDS; f++) begin
        out_avg_r[f] <= (f < CHANNELS) ? dq_r[(f < CHANNELS) ? f : 0] : '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_changed   = out_changed_r;
  assign out_average_0 = out_avg_r[0];
  assign out_average_1 = out_avg_r[1];
  assign out_average_2 = out_avg_r[2];
  assign out_average_3 = out_avg_r[3];
  assign out_average_4 = out_avg_r[4];
  assign out_average_5 = out_avg_r[5];
  assign out_average_6 = out_avg_r[6];
  assign out_average_7 = out_avg_r[7];

endmodule
